>>> hw/rtl/vssgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and types for the vinyl slow-speed gain and dither unit.
// No dependencies.

package vssgd_pkg;

   // field widths
   localparam int FPB_W      = 14;
   localparam int SLOW_W     = 13;
   localparam int DITH_W     = 15;
   localparam int SPEED_W    = 16;
   localparam int SAMP_W     = 16;
   localparam int OUT_W      = 24;
   localparam int RATE_W     = 32;
   localparam int FRAC_EXTRA = 15;
   localparam int GAIN_SHIFT = 7;

   // noise generator
   localparam int                LFSR_W    = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   // register defaults
   localparam logic [FPB_W-1:0]  FPB_RESET  = 14'd512;
   localparam logic [SLOW_W-1:0] SLOW_RESET = 13'd573;
   localparam logic [DITH_W-1:0] DITH_RESET = 15'd6963;

   // config port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FPB    = 2'd0,
      CSR_SLOW   = 2'd1,
      CSR_DITHER = 2'd2
   } csr_index_type;

   // shared divider: remainder width, shift register width, pair counter
   localparam int DIV_W     = 21;
   localparam int DIV_SR_W  = 32;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] STEP_PAIRS = 5'd16;   // 32 quotient bits
   localparam logic [DIV_CNT_W-1:0] GAIN_PAIRS = 5'd12;   // 24 quotient bits

   typedef struct packed {
      logic [FPB_W-1:0]  frames_per_block;
      logic [SLOW_W-1:0] slow_threshold;
      logic [DITH_W-1:0] dither_threshold;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     rem_init;
      logic [DIV_SR_W-1:0]  dividend;
      logic [DIV_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] pairs;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic                busy;
      logic [DIV_SR_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/vssgd_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// Configuration registers: block length and the two speed thresholds.
// Depends on vssgd_pkg.

module vssgd_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [vssgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [vssgd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output vssgd_pkg::cfg_type                       cfg
);

   vssgd_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            vssgd_pkg::CSR_FPB: begin
               cfg_in.frames_per_block = csr_wdata[vssgd_pkg::FPB_W-1:0];
            end
            vssgd_pkg::CSR_SLOW: begin
               cfg_in.slow_threshold = csr_wdata[vssgd_pkg::SLOW_W-1:0];
            end
            vssgd_pkg::CSR_DITHER: begin
               cfg_in.dither_threshold = csr_wdata[vssgd_pkg::DITH_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;   // unknown index: dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frames_per_block <= vssgd_pkg::FPB_RESET;
         cfg_ff.slow_threshold   <= vssgd_pkg::SLOW_RESET;
         cfg_ff.dither_threshold <= vssgd_pkg::DITH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/vssgd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared restoring divider, two quotient bits per cycle, unsigned.
// Depends on vssgd_pkg.

module vssgd_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  vssgd_pkg::div_req_type   req,
   output vssgd_pkg::div_rsp_type   rsp
);

   localparam int W  = vssgd_pkg::DIV_W;
   localparam int SW = vssgd_pkg::DIV_SR_W;
   localparam int CW = vssgd_pkg::DIV_CNT_W;

   logic [W-1:0]  rem_ff, rem_in;
   logic [SW-1:0] sr_ff, sr_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [W:0]    trial1, diff1, trial2, diff2;
   logic          ge1, ge2;
   logic [W-1:0]  rem_a;
   logic [SW-1:0] sr_a;

   // two dependent shift-subtract steps
   always_comb begin
      trial1 = {rem_ff, sr_ff[SW-1]};
      diff1  = trial1 - {1'b0, dvs_ff};
      ge1    = (trial1 >= {1'b0, dvs_ff});
      rem_a  = ge1 ? diff1[W-1:0] : trial1[W-1:0];
      sr_a   = {sr_ff[SW-2:0], ge1};

      trial2 = {rem_a, sr_a[SW-1]};
      diff2  = trial2 - {1'b0, dvs_ff};
      ge2    = (trial2 >= {1'b0, dvs_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      sr_in   = sr_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = req.rem_init;
         sr_in  = req.dividend;
         dvs_in = req.divisor;
         cnt_in = req.pairs;
      end else if (cnt_ff != '0) begin
         rem_in  = ge2 ? diff2[W-1:0] : trial2[W-1:0];
         sr_in   = {sr_a[SW-2:0], ge2};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sr_ff  <= sr_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.busy     = (cnt_ff != '0);
   assign rsp.quotient = sr_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vinyl_slow_speed_gain_dither_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the vinyl slow-speed gain and dither unit: sequencer, speed ramp,
// noise LFSR, shared multiplier and output register.
// Depends on vssgd_pkg, vssgd_csr and vssgd_div.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------------
//   req_    | in        | req_valid/req_stall  | block_start, target_speed, samples
//   rsp_    | out       | rsp_valid/rsp_stall  | left_out, right_out (Q16.8, sat.)
//   csr_    | in        | csr_valid/csr_ready  | index + write data, ready always high
//
// Sequencing: one word at a time. A frame outside the slow region runs capture,
// prepare, evaluate and output steps; a frame in the slow region adds two passes
// (multiply, divider load, divider wait that takes the quotient), left then right;
// a block start adds the ramp step division on the shared divider.
// Reset: synchronous, active high; clears the ramp, speed and LFSR (seed 0xACE1)
// and loads register defaults. No clearing pass.
// Stalls: a finished word waits in the output register while the next input is
// taken; the sequencer holds at its final step only while that register is full and rsp_stall is high.

module vinyl_slow_speed_gain_dither_unit (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // input words
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_block_start,
   input  wire logic signed [vssgd_pkg::SPEED_W-1:0]      req_target_speed,
   input  wire logic signed [vssgd_pkg::SAMP_W-1:0]       req_left_sample,
   input  wire logic signed [vssgd_pkg::SAMP_W-1:0]       req_right_sample,
   // result words
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic signed [vssgd_pkg::OUT_W-1:0]             rsp_left_out,
   output logic signed [vssgd_pkg::OUT_W-1:0]             rsp_right_out,
   // configuration
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [vssgd_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [vssgd_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int SPW = vssgd_pkg::SPEED_W;
   localparam int SMW = vssgd_pkg::SAMP_W;
   localparam int OW  = vssgd_pkg::OUT_W;
   localparam int RW  = vssgd_pkg::RATE_W;
   localparam int FX  = vssgd_pkg::FRAC_EXTRA;
   localparam int AW  = vssgd_pkg::SLOW_W + FX;   // |rate| width inside slow region
   localparam int PW  = SMW + AW;                 // product width
   localparam int QW  = OW + 1;                   // signed scaled sample
   localparam int SUMW = QW + 1;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_PREP = 11'b000_0000_0010,
      S_STEP = 11'b000_0000_0100,
      S_EVAL = 11'b000_0000_1000,
      S_MULL = 11'b000_0001_0000,
      S_LDL  = 11'b000_0010_0000,
      S_DIVL = 11'b000_0100_0000,
      S_MULR = 11'b000_1000_0000,
      S_LDR  = 11'b001_0000_0000,
      S_DIVR = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   vssgd_pkg::cfg_type     cfg;
   vssgd_pkg::div_req_type div_req;
   vssgd_pkg::div_rsp_type div_rsp;

   state_type state_ff, state_in;

   // captured input word
   logic                  blk_ff, blk_in;
   logic signed [SPW-1:0] target_ff, target_in;
   logic signed [SMW-1:0] left_ff, left_in;
   logic signed [SMW-1:0] right_ff, right_in;

   // ramp and noise state
   logic signed [SPW-1:0] old_speed_ff, old_speed_in;
   logic signed [RW-1:0]  rate_ff, rate_in;
   logic signed [RW-1:0]  step_ff, step_in;
   logic [vssgd_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;

   // per-frame working registers
   logic                  neg_ff, neg_in;
   logic [AW-1:0]         a_ff, a_in;
   logic signed [7:0]     noise_ff, noise_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic signed [QW-1:0]  lq_ff, lq_in;
   logic signed [QW-1:0]  rq_ff, rq_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]  rsp_left_ff, rsp_left_in;
   logic signed [OW-1:0]  rsp_right_ff, rsp_right_in;

   // combinational helpers
   logic signed [SPW:0]   diff;
   logic [SPW:0]          diff_mag;
   logic [vssgd_pkg::FPB_W-1:0] len;
   logic [RW-1:0]         a_full;
   logic                  dith_hit, gain_hit;
   logic signed [SMW-1:0] mul_src;
   logic [SMW-1:0]        mul_mag;
   logic [QW-1:0]         qmag;
   logic signed [SUMW-1:0] sum_l, sum_r;
   logic signed [RW:0]    rate_sum;

   function automatic logic signed [OW-1:0] sat_out(input logic signed [SUMW-1:0] v);
      logic signed [SUMW-1:0] hi;
      logic signed [SUMW-1:0] lo;
      hi = SUMW'({1'b0, {(OW-1){1'b1}}});
      lo = -hi - SUMW'(1);
      if (v > hi)      sat_out = hi[OW-1:0];
      else if (v < lo) sat_out = lo[OW-1:0];
      else             sat_out = v[OW-1:0];
   endfunction

   vssgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vssgd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // datapath terms
   always_comb begin
      diff     = {target_ff[SPW-1], target_ff} - {old_speed_ff[SPW-1], old_speed_ff};
      diff_mag = diff[SPW] ? (SPW+1)'(-diff) : diff;
      // zero block length behaves as one
      len      = (cfg.frames_per_block == '0) ? vssgd_pkg::FPB_W'(1) : cfg.frames_per_block;

      a_full   = rate_ff[RW-1] ? RW'(-rate_ff) : rate_ff;
      dith_hit = a_full < RW'({cfg.dither_threshold, {FX{1'b0}}});
      gain_hit = (cfg.slow_threshold != '0) &&
                 (a_full < RW'({cfg.slow_threshold, {FX{1'b0}}}));

      mul_src  = (state_ff == S_MULR) ? right_ff : left_ff;
      mul_mag  = mul_src[SMW-1] ? SMW'(-mul_src) : mul_src;

      qmag     = {1'b0, div_rsp.quotient[OW-1:0]};

      sum_l    = {lq_ff[QW-1], lq_ff} + SUMW'(noise_ff);
      sum_r    = {rq_ff[QW-1], rq_ff} + SUMW'(noise_ff);

      rate_sum = {rate_ff[RW-1], rate_ff} + {step_ff[RW-1], step_ff};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      target_in    = target_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      old_speed_in = old_speed_ff;
      rate_in      = rate_ff;
      step_in      = step_ff;
      lfsr_in      = lfsr_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      noise_in     = noise_ff;
      prod_in      = prod_ff;
      lq_in        = lq_ff;
      rq_in        = rq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.dividend = {diff_mag, {FX{1'b0}}};
      div_req.divisor  = vssgd_pkg::DIV_W'(len);
      div_req.pairs    = vssgd_pkg::STEP_PAIRS;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               blk_in    = req_block_start;
               target_in = req_target_speed;
               left_in   = req_left_sample;
               right_in  = req_right_sample;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            if (blk_ff) begin
               // ramp restarts at the old speed; step = diff / len toward zero
               div_req.start = 1'b1;
               neg_in        = diff[SPW];
               rate_in       = {old_speed_ff[SPW-1], old_speed_ff, {FX{1'b0}}};
               old_speed_in  = target_ff;
               state_in      = S_STEP;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_STEP: begin
            if (div_rsp.done) begin
               step_in  = neg_ff ? RW'(-div_rsp.quotient) : div_rsp.quotient;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            a_in = a_full[AW-1:0];
            if (dith_hit) begin
               // LFSR top byte minus 128: flip its sign bit
               noise_in = {~lfsr_ff[15], lfsr_ff[14:8]};
               lfsr_in  = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ vssgd_pkg::LFSR_TAPS)
                                     : (lfsr_ff >> 1);
            end else begin
               noise_in = '0;
            end
            if (gain_hit) begin
               state_in = S_MULL;
            end else begin
               lq_in    = {left_ff[SMW-1], left_ff, 8'b0};
               rq_in    = {right_ff[SMW-1], right_ff, 8'b0};
               state_in = S_DONE;
            end
         end
         S_MULL: begin
            prod_in  = mul_mag * a_ff;
            state_in = S_LDL;
         end
         S_LDL: begin
            div_req.start    = 1'b1;
            div_req.rem_init = vssgd_pkg::DIV_W'(prod_ff[PW-1:OW]);
            div_req.dividend = {prod_ff[OW-1:0], 8'b0};
            div_req.divisor  = vssgd_pkg::DIV_W'({cfg.slow_threshold,
                                                  {vssgd_pkg::GAIN_SHIFT{1'b0}}});
            div_req.pairs    = vssgd_pkg::GAIN_PAIRS;
            state_in         = S_DIVL;
         end
         S_DIVL: begin
            if (div_rsp.done) begin
               lq_in    = left_ff[SMW-1] ? QW'(-qmag) : qmag;
               state_in = S_MULR;
            end
         end
         S_MULR: begin
            prod_in  = mul_mag * a_ff;
            state_in = S_LDR;
         end
         S_LDR: begin
            div_req.start    = 1'b1;
            div_req.rem_init = vssgd_pkg::DIV_W'(prod_ff[PW-1:OW]);
            div_req.dividend = {prod_ff[OW-1:0], 8'b0};
            div_req.divisor  = vssgd_pkg::DIV_W'({cfg.slow_threshold,
                                                  {vssgd_pkg::GAIN_SHIFT{1'b0}}});
            div_req.pairs    = vssgd_pkg::GAIN_PAIRS;
            state_in         = S_DIVR;
         end
         S_DIVR: begin
            if (div_rsp.done) begin
               rq_in    = right_ff[SMW-1] ? QW'(-qmag) : qmag;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = sat_out(sum_l);
               rsp_right_in = sat_out(sum_r);
               // advance ramp, saturating at the 32-bit limits
               if (rate_sum[RW] != rate_sum[RW-1]) begin
                  rate_in = rate_sum[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
               end else begin
                  rate_in = rate_sum[RW-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      blk_in_reg: begin
         blk_ff       <= blk_in;
         target_ff    <= target_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         neg_ff       <= neg_in;
         a_ff         <= a_in;
         noise_ff     <= noise_in;
         prod_ff      <= prod_in;
         lq_ff        <= lq_in;
         rq_ff        <= rq_in;
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         old_speed_ff <= '0;
         rate_ff      <= '0;
         step_ff      <= '0;
         lfsr_ff      <= vssgd_pkg::LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         old_speed_ff <= old_speed_in;
         rate_ff      <= rate_in;
         step_ff      <= step_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   // divider results only turn up while the sequencer waits for one
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_STEP || state_ff == S_DIVL || state_ff == S_DIVR))
      else $error("divider finished outside a wait step");

   // scaled sample magnitude stays below 2^23
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done && (state_ff == S_DIVL || state_ff == S_DIVR)
      |-> div_rsp.quotient[RW-1:OW-1] == '0)
      else $error("gain quotient out of range");

   // a new result word only follows the final step of a frame
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word without a finished frame");

   // no divider start while it is still working
   a_div_no_overlap: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

endmodule

`default_nettype wire
